@@ rtl/gbn_pkg.sv @@
// Shared types and constants for the go-back-N sender window.
// Request/result payloads, result kinds, opcodes, controller state and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gbn_pkg;

  // opcodes carried by a request
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RETRIES = 2'd2;
  localparam logic [1:0] REG_TOTAL   = 2'd3;

  localparam logic [3:0]  WINDOW_RST  = 4'd15;
  localparam logic [15:0] TIMEOUT_RST = 16'd50;
  localparam logic [7:0]  RETRIES_RST = 8'd10;
  localparam logic [15:0] TOTAL_RST   = 16'd15;

  typedef enum logic [3:0] {
    KIND_SENT     = 4'd0,
    KIND_RESENT   = 4'd1,
    KIND_ACK_TAKEN = 4'd2,
    KIND_ACK_IGN  = 4'd3,
    KIND_WAITING  = 4'd4,
    KIND_COMPLETE = 4'd5,
    KIND_FAILED   = 4'd6,
    KIND_ASSUMED  = 4'd7,
    KIND_STARTED  = 4'd8,
    KIND_NONE     = 4'd9
  } kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] ack_seq;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  frame_seq;
    logic [15:0] packet_index;
    logic        end_frame;
    logic        run_last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND,
    ST_RESEND,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic  load_req;
    logic  do_start;
    logic  do_send;
    logic  do_ack;
    logic  tick_count;
    logic  tick_end;
    logic  tick_resend;
    logic  do_resend;
    logic  clr_active;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       active;
    logic       slot_free;
    logic       can_send;
    logic       can_send_next;
    logic       ack_in_win;
    logic       ack_complete;
    logic       tick_timeout;
    logic       retry_end;
    logic       all_sent;
    logic       outs_zero;
    logic       resend_last;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/gbn_ctrl.sv @@
// Controller FSM for the go-back-N sender window.
// Sequences one request at a time into datapath commands. Uses gbn_pkg.
`default_nettype none

module gbn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire gbn_pkg::stat_t stat,
  output gbn_pkg::cmd_t      cmd
);

  gbn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::ST_IDLE: begin
        if (req_valid) state_next = gbn_pkg::ST_EXEC;
      end
      gbn_pkg::ST_EXEC: begin
        if (stat.slot_free) begin
          state_next = gbn_pkg::ST_IDLE;
          case (stat.op)
            gbn_pkg::OP_FILL: begin
              if (stat.active && stat.can_send) state_next = gbn_pkg::ST_SEND;
            end
            gbn_pkg::OP_ACK: begin
              if (stat.active && stat.ack_complete) state_next = gbn_pkg::ST_DONE;
            end
            gbn_pkg::OP_TICK: begin
              if (stat.active && stat.tick_timeout && !stat.retry_end && !stat.outs_zero)
                state_next = gbn_pkg::ST_RESEND;
            end
            default: state_next = gbn_pkg::ST_IDLE;
          endcase
        end
      end
      gbn_pkg::ST_SEND: begin
        if (stat.slot_free && !stat.can_send_next) state_next = gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_RESEND: begin
        if (stat.slot_free && stat.resend_last) state_next = gbn_pkg::ST_IDLE;
      end
      gbn_pkg::ST_DONE: begin
        if (stat.slot_free) state_next = gbn_pkg::ST_IDLE;
      end
      default: state_next = gbn_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.emit_kind = gbn_pkg::KIND_NONE;
    req_stall = 1'b1;
    case (state)
      gbn_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load_req = req_valid;
      end
      gbn_pkg::ST_EXEC: begin
        if (stat.slot_free) begin
          case (stat.op)
            gbn_pkg::OP_START: begin
              cmd.do_start  = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_kind = gbn_pkg::KIND_STARTED;
              cmd.emit_last = 1'b1;
            end
            gbn_pkg::OP_FILL: begin
              if (!(stat.active && stat.can_send)) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = gbn_pkg::KIND_NONE;
                cmd.emit_last = 1'b1;
              end
            end
            gbn_pkg::OP_ACK: begin
              cmd.emit = 1'b1;
              if (!stat.active) begin
                cmd.emit_kind = gbn_pkg::KIND_ACK_IGN;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.do_ack    = 1'b1;
                cmd.emit_kind = stat.ack_in_win ? gbn_pkg::KIND_ACK_TAKEN
                                                : gbn_pkg::KIND_ACK_IGN;
                cmd.emit_last = !stat.ack_complete;
              end
            end
            gbn_pkg::OP_TICK: begin
              if (!stat.active) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = gbn_pkg::KIND_WAITING;
                cmd.emit_last = 1'b1;
              end else if (!stat.tick_timeout) begin
                cmd.tick_count = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_kind  = gbn_pkg::KIND_WAITING;
                cmd.emit_last  = 1'b1;
              end else if (stat.retry_end) begin
                cmd.tick_end  = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_kind = stat.all_sent ? gbn_pkg::KIND_ASSUMED
                                              : gbn_pkg::KIND_FAILED;
                cmd.emit_last = 1'b1;
              end else begin
                cmd.tick_resend = 1'b1;
                if (stat.outs_zero) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = gbn_pkg::KIND_NONE;
                  cmd.emit_last = 1'b1;
                end
              end
            end
            default: cmd.emit = 1'b0;
          endcase
        end
      end
      gbn_pkg::ST_SEND: begin
        if (stat.slot_free) begin
          cmd.do_send   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = gbn_pkg::KIND_SENT;
          cmd.emit_last = !stat.can_send_next;
        end
      end
      gbn_pkg::ST_RESEND: begin
        if (stat.slot_free) begin
          cmd.do_resend = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = gbn_pkg::KIND_RESENT;
          cmd.emit_last = stat.resend_last;
        end
      end
      gbn_pkg::ST_DONE: begin
        if (stat.slot_free) begin
          cmd.clr_active = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = gbn_pkg::KIND_COMPLETE;
          cmd.emit_last  = 1'b1;
        end
      end
      default: req_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/gbn_dp.sv @@
// Datapath for the go-back-N sender window: config registers, window state,
// resend cursor and the result register. Driven by gbn_ctrl; uses gbn_pkg.
`default_nettype none

module gbn_dp #(
  parameter int SEQ_COUNT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gbn_pkg::req_t  req,
  output gbn_pkg::rsp_t       rsp,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  input  wire gbn_pkg::cmd_t  cmd,
  output gbn_pkg::stat_t      stat
);

  localparam int SEQ_W = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int OW    = ((SEQ_W > 4) ? SEQ_W : 4) + 1;
  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(SEQ_COUNT - 1);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
    seq_inc = (a == SEQ_MAX) ? '0 : a + SEQ_W'(1);
  endfunction

  // (a - b) mod SEQ_COUNT
  function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic [OW-1:0] d;
    if (a >= b) d = OW'(a) - OW'(b);
    else        d = OW'(a) + OW'(SEQ_COUNT) - OW'(b);
    seq_sub = d[SEQ_W-1:0];
  endfunction

  // config
  logic [3:0]  window_size;
  logic [15:0] timeout_ticks;
  logic [7:0]  retry_limit;
  logic [15:0] total_packets;

  // window state
  gbn_pkg::req_t    req_q;
  logic [SEQ_W-1:0] base_seq, next_seq;
  logic [15:0]      sent_count, base_count;
  logic [15:0]      wait_timer;
  logic [7:0]       retry_count;
  logic             transfer_active;

  // resend cursor
  logic [SEQ_W-1:0] rs_seq, rs_left;
  logic [15:0]      rs_idx;

  logic [SEQ_W-1:0] outs, ack_off, ack_s;
  logic [OW-1:0]    outs_x, win_lim, ack_x, seq_x;
  logic             ack_ok, in_win;
  logic [15:0]      new_bc, timer_inc, sel_idx;
  logic [7:0]       retry_inc;
  logic             slot_free, sel_end;

  always_comb begin
    outs    = seq_sub(next_seq, base_seq);
    outs_x  = OW'(outs);
    win_lim = (OW'(window_size) > OW'(SEQ_COUNT - 1)) ? OW'(SEQ_COUNT - 1)
                                                      : OW'(window_size);
    ack_x   = OW'(req_q.ack_seq);
    ack_ok  = ack_x < OW'(SEQ_COUNT);
    ack_s   = ack_x[SEQ_W-1:0];
    ack_off = seq_sub(ack_s, base_seq);
    in_win  = ack_ok && (OW'(ack_off) < outs_x);
    new_bc  = in_win ? base_count + 16'(ack_off) + 16'd1 : base_count;
    timer_inc = (wait_timer == 16'hFFFF) ? wait_timer : wait_timer + 16'd1;
    retry_inc = (retry_count == 8'hFF) ? retry_count : retry_count + 8'd1;
    slot_free = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    stat.op            = req_q.opcode;
    stat.active        = transfer_active;
    stat.slot_free     = slot_free;
    stat.can_send      = (outs_x < win_lim) && (sent_count < total_packets);
    stat.can_send_next = ((outs_x + OW'(1)) < win_lim) &&
                         ((17'(sent_count) + 17'd1) < 17'(total_packets));
    stat.ack_in_win    = in_win;
    stat.ack_complete  = (new_bc == total_packets) && (sent_count == total_packets);
    stat.tick_timeout  = !(timer_inc < timeout_ticks);
    stat.retry_end     = retry_inc >= retry_limit;
    stat.all_sent      = sent_count >= total_packets;
    stat.outs_zero     = (outs == '0);
    stat.resend_last   = (rs_left == SEQ_W'(1));
  end

  // frame fields of the result being emitted
  always_comb begin
    seq_x   = OW'(cmd.do_resend ? rs_seq : next_seq);
    sel_idx = cmd.do_resend ? rs_idx : sent_count;
    sel_end = (total_packets != 16'd0) && (sel_idx == total_packets - 16'd1);
  end

  // APB config
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= gbn_pkg::WINDOW_RST;
      timeout_ticks <= gbn_pkg::TIMEOUT_RST;
      retry_limit   <= gbn_pkg::RETRIES_RST;
      total_packets <= gbn_pkg::TOTAL_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        gbn_pkg::REG_WINDOW:  window_size   <= pwdata[3:0];
        gbn_pkg::REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        gbn_pkg::REG_RETRIES: retry_limit   <= pwdata[7:0];
        gbn_pkg::REG_TOTAL:   total_packets <= pwdata[15:0];
        default:              window_size   <= window_size;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gbn_pkg::REG_WINDOW:  prdata = 32'(window_size);
      gbn_pkg::REG_TIMEOUT: prdata = 32'(timeout_ticks);
      gbn_pkg::REG_RETRIES: prdata = 32'(retry_limit);
      gbn_pkg::REG_TOTAL:   prdata = 32'(total_packets);
      default:              prdata = '0;
    endcase
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq        <= '0;
      next_seq        <= '0;
      sent_count      <= '0;
      base_count      <= '0;
      wait_timer      <= '0;
      retry_count     <= '0;
      transfer_active <= 1'b0;
    end else begin
      if (cmd.do_start) begin
        base_seq        <= '0;
        next_seq        <= '0;
        sent_count      <= '0;
        base_count      <= '0;
        wait_timer      <= '0;
        retry_count     <= '0;
        transfer_active <= 1'b1;
      end
      if (cmd.do_send) begin
        next_seq   <= seq_inc(next_seq);
        sent_count <= sent_count + 16'd1;
      end
      if (cmd.do_ack) begin
        // cumulative ACK: window slides past ack_seq
        if (in_win) begin
          base_seq   <= seq_inc(ack_s);
          base_count <= new_bc;
        end
        wait_timer  <= '0;
        retry_count <= '0;
      end
      if (cmd.tick_count) wait_timer <= timer_inc;
      if (cmd.tick_end) begin
        wait_timer      <= timer_inc;
        retry_count     <= retry_inc;
        transfer_active <= 1'b0;
      end
      if (cmd.tick_resend) begin
        wait_timer  <= '0;
        retry_count <= retry_inc;
      end
      if (cmd.clr_active) transfer_active <= 1'b0;
    end
  end

  // request latch and resend cursor (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_q <= req;
    if (cmd.tick_resend) begin
      rs_seq  <= base_seq;
      rs_idx  <= base_count;
      rs_left <= outs;
    end else if (cmd.do_resend) begin
      rs_seq  <= seq_inc(rs_seq);
      rs_idx  <= rs_idx + 16'd1;
      rs_left <= rs_left - SEQ_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.kind     <= cmd.emit_kind;
      rsp.run_last <= cmd.emit_last;
      if (cmd.do_send || cmd.do_resend) begin
        rsp.frame_seq    <= seq_x[3:0];
        rsp.packet_index <= sel_idx;
        rsp.end_frame    <= sel_end;
      end else begin
        rsp.frame_seq    <= '0;
        rsp.packet_index <= '0;
        rsp.end_frame    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/go_back_n_sender_window.sv @@
// Channel  Dir  Handshake          Payload
// req      in   req_valid/req_stall gbn_pkg::req_t  (opcode, ack_seq)
// rsp      out  rsp_valid/rsp_stall gbn_pkg::rsp_t  (kind, frame_seq, packet_index,
//                                                   end_frame, run_last)
// cfg      in   APB psel/penable    window size, timeout ticks, retry limit,
//                                   total packets at 0x0/0x4/0x8/0xC
//
// Sequencing: one request at a time. A request is taken in the idle state and
//   decided in EXEC once the result register has room. Start, ACK, tick and
//   empty fill are emitted from EXEC; an ACK that completes the transfer adds
//   DONE. A fill or resend emits its frames from SEND or RESEND, as the decide
//   state emits nothing. The single result register sets the pace.
// Reset: synchronous, active high; config returns to 15/50/10/15, window
//   state clears and the transfer is inactive.
// Stalls: rsp_stall holds the result register; the controller waits until
//   the register drains before loading the next result.
//
// Top level of the go-back-N sender window. Ties gbn_ctrl and gbn_dp; uses
// gbn_pkg.
`default_nettype none

module go_back_n_sender_window #(
  parameter int SEQ_COUNT = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // request channel
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire gbn_pkg::req_t req,
  // result channel
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output gbn_pkg::rsp_t      rsp,
  // config port
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gbn_pkg::cmd_t  cmd;
  gbn_pkg::stat_t stat;

  // config writes complete in the access cycle, never wait
  assign pready = 1'b1;

  // FSM: one request in flight, steps the fill and resend loops
  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // window counters, timer, retry count, config and result register
  gbn_dp #(
    .SEQ_COUNT (SEQ_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
